// ----- rtl/opbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opbp_pkg
// Types, codes and character constants shared by the OSC packet byte parser.
// ----------------------------------------------------------------------------
package opbp_pkg;

   typedef enum logic [12:0] {
      PH_START     = 13'b0000000000001,
      PH_HEADER    = 13'b0000000000010,
      PH_TIMETAG   = 13'b0000000000100,
      PH_ELEM      = 13'b0000000001000,
      PH_ADDR      = 13'b0000000010000,
      PH_TAG_FIRST = 13'b0000000100000,
      PH_TAGS      = 13'b0000001000000,
      PH_ARG       = 13'b0000010000000,
      PH_BDATA     = 13'b0000100000000,
      PH_BPAD      = 13'b0001000000000,
      PH_SKIP      = 13'b0010000000000,
      PH_FILL      = 13'b0100000000000,
      PH_DISCARD   = 13'b1000000000000
   } phase_type;

   localparam logic [3:0] CLS_BUNDLE_HDR = 4'd0;
   localparam logic [3:0] CLS_TIMETAG    = 4'd1;
   localparam logic [3:0] CLS_ELEM_SIZE  = 4'd2;
   localparam logic [3:0] CLS_ADDR       = 4'd3;
   localparam logic [3:0] CLS_ADDR_PAD   = 4'd4;
   localparam logic [3:0] CLS_TAG        = 4'd5;
   localparam logic [3:0] CLS_TAG_PAD    = 4'd6;
   localparam logic [3:0] CLS_INT        = 4'd7;
   localparam logic [3:0] CLS_FLOAT      = 4'd8;
   localparam logic [3:0] CLS_STRING     = 4'd9;
   localparam logic [3:0] CLS_STRING_PAD = 4'd10;
   localparam logic [3:0] CLS_BLOB_SIZE  = 4'd11;
   localparam logic [3:0] CLS_BLOB_DATA  = 4'd12;
   localparam logic [3:0] CLS_BLOB_PAD   = 4'd13;

   localparam logic [2:0] TAG_INT    = 3'd0;
   localparam logic [2:0] TAG_FLOAT  = 3'd1;
   localparam logic [2:0] TAG_STRING = 3'd2;
   localparam logic [2:0] TAG_BLOB   = 3'd3;
   localparam logic [2:0] TAG_OTHER  = 3'd4;

   localparam logic [1:0] KIND_INT    = 2'd0;
   localparam logic [1:0] KIND_FLOAT  = 2'd1;
   localparam logic [1:0] KIND_STRING = 2'd2;
   localparam logic [1:0] KIND_BLOB   = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
   localparam logic [2:0] ERR_NO_COMMA   = 3'd2;
   localparam logic [2:0] ERR_TOO_MANY   = 3'd3;
   localparam logic [2:0] ERR_EARLY_END  = 3'd4;

   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [3:0] byte_class;
      logic [7:0] message_number;
      logic [3:0] arg_number;
      logic [1:0] arg_kind;
      logic [1:0] word_lane;
      logic       message_done;
      logic       packet_done;
      logic [2:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic [3:0] arg_number;
      logic [1:0] arg_kind;
   } tag_entry_type;

   function automatic logic [7:0] bundle_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = CHAR_HASH;
         3'd1:    ch = 8'h62;
         3'd2:    ch = 8'h75;
         3'd3:    ch = 8'h6e;
         3'd4:    ch = 8'h64;
         3'd5:    ch = 8'h6c;
         3'd6:    ch = 8'h65;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] tag_decode(input logic [7:0] ch);
      logic [2:0] code;
      case (ch)
         CHAR_I:  code = TAG_INT;
         CHAR_F:  code = TAG_FLOAT;
         CHAR_S:  code = TAG_STRING;
         CHAR_B:  code = TAG_BLOB;
         default: code = TAG_OTHER;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/opbp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opbp_if
// Valid/ready channels for packet bytes in and labeled bytes out.
// ----------------------------------------------------------------------------
interface opbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;

   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

interface opbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] byte_class;
   logic [7:0] message_number;
   logic [3:0] arg_number;
   logic [1:0] arg_kind;
   logic [1:0] word_lane;
   logic       message_done;
   logic       packet_done;
   logic [2:0] error_code;

   modport source (output valid, output byte_class, output message_number,
                   output arg_number, output arg_kind, output word_lane,
                   output message_done, output packet_done, output error_code,
                   input ready);
   modport sink (input valid, input byte_class, input message_number,
                 input arg_number, input arg_kind, input word_lane,
                 input message_done, input packet_done, input error_code,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/opbp_tag_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opbp_tag_mem
// Argument list of the current message: one write port, one registered read.
// ----------------------------------------------------------------------------
module opbp_tag_mem
   import opbp_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire tag_entry_type wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output tag_entry_type      rd_data_ff
);

   tag_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/opbp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opbp_parser
// Parse state and per-byte labeling; state advances once per transaction.
// ----------------------------------------------------------------------------
module opbp_parser
   import opbp_pkg::*;
#(
   parameter int MAX_TAGS = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire req_type       req,
   input  wire tag_entry_type rd_data,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output tag_entry_type      wr_data,
   output logic [AW-1:0]      rd_addr,
   output rsp_type            rsp
);

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TAGS);

   phase_type     phase_ff, phase_in;
   logic [3:0]    hdr_ff, hdr_in;
   logic [1:0]    lane_ff, lane_in;
   logic          null_ff, null_in;
   logic          bundle_ff, bundle_in;
   logic [CW-1:0] tag_total_ff, tag_total_in;
   logic [CW-1:0] arg_count_ff, arg_count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [31:0]   gather_ff, gather_in;
   logic [31:0]   bytes_left_ff, bytes_left_in;
   logic [31:0]   elem_left_ff, elem_left_in;
   logic [7:0]    msg_count_ff, msg_count_in;
   logic [2:0]    err_ff, err_in;

   phase_type     ph;
   phase_type     before_ph;
   logic [7:0]    b;
   logic          lane3;
   logic          nul_now;
   logic [31:0]   gather_next;
   logic [31:0]   count_dn;
   logic [2:0]    tag_code;
   logic          do_next;
   logic [CW-1:0] next_idx;
   logic          finished;
   logic          clean;
   logic [3:0]    cls;
   logic [3:0]    argn;
   logic [1:0]    kind;
   logic          done;

   always_comb begin
      phase_in      = phase_ff;
      hdr_in        = hdr_ff;
      null_in       = null_ff;
      bundle_in     = bundle_ff;
      tag_total_in  = tag_total_ff;
      arg_count_in  = arg_count_ff;
      cursor_in     = cursor_ff;
      gather_in     = gather_ff;
      bytes_left_in = bytes_left_ff;
      elem_left_in  = elem_left_ff;
      msg_count_in  = msg_count_ff;
      err_in        = err_ff;
      lane_in       = lane_ff + 2'd1;
      b             = req.data_byte;
      lane3         = (lane_ff == 2'd3);
      nul_now       = null_ff | (b == CHAR_NUL);
      gather_next   = {gather_ff[23:0], b};
      count_dn      = 32'd0;
      tag_code      = tag_decode(b);
      do_next       = 1'b0;
      next_idx      = cursor_ff + CW'(1);
      finished      = 1'b0;
      clean         = 1'b0;
      cls           = CLS_STRING_PAD;
      argn          = 4'd0;
      kind          = KIND_INT;
      done          = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = arg_count_ff[AW-1:0];
      wr_data.arg_number = 4'(tag_total_ff);
      wr_data.arg_kind   = tag_code[1:0];

      ph = phase_ff;
      if (phase_ff == PH_START) begin
         ph = (b == CHAR_HASH) ? PH_HEADER : PH_ADDR;
      end
      before_ph = ph;
      phase_in  = ph;

      if (ph == PH_ARG || ph == PH_BDATA || ph == PH_BPAD) begin
         argn = rd_data.arg_number;
         kind = rd_data.arg_kind;
      end

      unique case (ph)
         PH_HEADER: begin
            cls = CLS_BUNDLE_HDR;
            if (b != bundle_char(hdr_ff[2:0])) begin
               if (err_in == ERR_NONE) err_in = ERR_BAD_HEADER;
               phase_in = PH_DISCARD;
            end else if (hdr_ff == 4'd7) begin
               bundle_in = 1'b1;
               phase_in  = PH_TIMETAG;
               hdr_in    = 4'd0;
            end else begin
               hdr_in = hdr_ff + 4'd1;
            end
         end
         PH_TIMETAG: begin
            cls = CLS_TIMETAG;
            if (hdr_ff == 4'd7) begin
               phase_in  = PH_ELEM;
               hdr_in    = 4'd0;
               gather_in = 32'd0;
            end else begin
               hdr_in = hdr_ff + 4'd1;
            end
         end
         PH_ELEM: begin
            cls = CLS_ELEM_SIZE;
            if (hdr_ff == 4'd3) begin
               hdr_in       = 4'd0;
               elem_left_in = gather_next;
               gather_in    = 32'd0;
               if (gather_next != 32'd0) begin
                  phase_in     = PH_ADDR;
                  null_in      = 1'b0;
                  tag_total_in = '0;
                  arg_count_in = '0;
                  cursor_in    = '0;
               end
            end else begin
               gather_in = gather_next;
               hdr_in    = hdr_ff + 4'd1;
            end
         end
         PH_ADDR: begin
            cls     = nul_now ? CLS_ADDR_PAD : CLS_ADDR;
            null_in = nul_now;
            if (nul_now && lane3) begin
               null_in  = 1'b0;
               phase_in = PH_TAG_FIRST;
            end
         end
         PH_TAG_FIRST: begin
            cls = CLS_TAG;
            if (b == CHAR_COMMA) begin
               phase_in = PH_TAGS;
               null_in  = 1'b0;
            end else begin
               if (err_in == ERR_NONE) err_in = ERR_NO_COMMA;
               phase_in = PH_SKIP;
            end
         end
         PH_TAGS: begin
            if (!null_ff && b != CHAR_NUL) begin
               cls = CLS_TAG;
               if (tag_total_ff >= MAX_CNT) begin
                  if (err_in == ERR_NONE) err_in = ERR_TOO_MANY;
                  phase_in = PH_SKIP;
               end else begin
                  if (tag_code != TAG_OTHER) begin
                     wr_en        = 1'b1;
                     arg_count_in = arg_count_ff + CW'(1);
                  end
                  tag_total_in = tag_total_ff + CW'(1);
               end
            end else begin
               cls     = CLS_TAG_PAD;
               null_in = 1'b1;
               if (lane3) begin
                  null_in  = 1'b0;
                  do_next  = 1'b1;
                  next_idx = '0;
               end
            end
         end
         PH_ARG: begin
            case (kind)
               KIND_STRING: begin
                  cls     = nul_now ? CLS_STRING_PAD : CLS_STRING;
                  null_in = nul_now;
                  if (nul_now && lane3) begin
                     null_in = 1'b0;
                     do_next = 1'b1;
                  end
               end
               KIND_BLOB: begin
                  cls    = CLS_BLOB_SIZE;
                  hdr_in = hdr_ff + 4'd1;
                  if (hdr_ff == 4'd3) begin
                     bytes_left_in = gather_next;
                     gather_in     = 32'd0;
                     if (gather_next != 32'd0) begin
                        phase_in = PH_BDATA;
                     end else if (lane3) begin
                        do_next = 1'b1;
                     end else begin
                        phase_in = PH_BPAD;
                     end
                  end else begin
                     gather_in = gather_next;
                  end
               end
               default: begin
                  cls    = (kind == KIND_FLOAT) ? CLS_FLOAT : CLS_INT;
                  hdr_in = hdr_ff + 4'd1;
                  if (hdr_ff == 4'd3) begin
                     do_next = 1'b1;
                  end
               end
            endcase
         end
         PH_BDATA: begin
            cls      = CLS_BLOB_DATA;
            count_dn = (bytes_left_ff != 32'd0) ? bytes_left_ff - 32'd1 : bytes_left_ff;
            bytes_left_in = count_dn;
            if (count_dn == 32'd0) begin
               if (lane3) begin
                  do_next = 1'b1;
               end else begin
                  phase_in = PH_BPAD;
               end
            end
         end
         PH_BPAD: begin
            cls = CLS_BLOB_PAD;
            if (lane3) begin
               do_next = 1'b1;
            end
         end
         PH_SKIP, PH_FILL: begin
            cls = CLS_STRING_PAD;
         end
         default: begin
            cls      = CLS_BUNDLE_HDR;
            phase_in = PH_DISCARD;
         end
      endcase

      // step to the next argument that takes bytes
      if (do_next) begin
         cursor_in = next_idx;
         if (next_idx >= arg_count_ff) begin
            finished = 1'b1;
         end else begin
            phase_in  = PH_ARG;
            null_in   = 1'b0;
            hdr_in    = 4'd0;
            gather_in = 32'd0;
         end
      end

      if (finished) begin
         phase_in = PH_FILL;
         if (!bundle_ff) begin
            done = 1'b1;
            if (msg_count_ff != 8'hff) msg_count_in = msg_count_ff + 8'd1;
         end
      end

      // element boundary inside a bundle
      if (bundle_ff && (before_ph == PH_ADDR || before_ph == PH_TAG_FIRST ||
                        before_ph == PH_TAGS || before_ph == PH_ARG ||
                        before_ph == PH_BDATA || before_ph == PH_BPAD ||
                        before_ph == PH_SKIP || before_ph == PH_FILL)) begin
         elem_left_in = (elem_left_ff != 32'd0) ? elem_left_ff - 32'd1 : elem_left_ff;
         if (elem_left_in == 32'd0) begin
            if (phase_in != PH_TAG_FIRST && phase_in != PH_FILL) begin
               if (err_in == ERR_NONE) err_in = ERR_EARLY_END;
            end
            done = 1'b1;
            if (msg_count_in != 8'hff) msg_count_in = msg_count_in + 8'd1;
            phase_in  = PH_ELEM;
            hdr_in    = 4'd0;
            gather_in = 32'd0;
         end
      end

      if (req.packet_end) begin
         if (phase_in == PH_DISCARD) begin
            clean = 1'b1;
         end else if (bundle_in) begin
            clean = (phase_in == PH_ELEM) && (hdr_in == 4'd0);
         end else begin
            clean = (phase_in == PH_TAG_FIRST) || (phase_in == PH_FILL);
         end
         if (!clean && err_in == ERR_NONE) err_in = ERR_EARLY_END;
         if (phase_in == PH_ADDR || phase_in == PH_TAG_FIRST || phase_in == PH_TAGS ||
             phase_in == PH_ARG || phase_in == PH_BDATA || phase_in == PH_BPAD ||
             phase_in == PH_SKIP || (bundle_in && phase_in == PH_FILL)) begin
            done = 1'b1;
         end
      end

      rsp.byte_class     = cls;
      rsp.message_number = msg_count_ff;
      rsp.arg_number     = argn;
      rsp.arg_kind       = kind;
      rsp.word_lane      = lane_ff;
      rsp.message_done   = done;
      rsp.packet_done    = req.packet_end;
      rsp.error_code     = err_in;

      // return to packet start after the last byte
      if (req.packet_end) begin
         phase_in      = PH_START;
         hdr_in        = 4'd0;
         lane_in       = 2'd0;
         null_in       = 1'b0;
         bundle_in     = 1'b0;
         tag_total_in  = '0;
         arg_count_in  = '0;
         cursor_in     = '0;
         gather_in     = 32'd0;
         bytes_left_in = 32'd0;
         elem_left_in  = 32'd0;
         msg_count_in  = 8'd0;
         err_in        = ERR_NONE;
      end

      wr_en   = wr_en & advance;
      rd_addr = advance ? cursor_in[AW-1:0] : cursor_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         hdr_ff        <= 4'd0;
         lane_ff       <= 2'd0;
         null_ff       <= 1'b0;
         bundle_ff     <= 1'b0;
         tag_total_ff  <= '0;
         arg_count_ff  <= '0;
         cursor_ff     <= '0;
         gather_ff     <= 32'd0;
         bytes_left_ff <= 32'd0;
         elem_left_ff  <= 32'd0;
         msg_count_ff  <= 8'd0;
         err_ff        <= ERR_NONE;
      end else if (advance) begin
         phase_ff      <= phase_in;
         hdr_ff        <= hdr_in;
         lane_ff       <= lane_in;
         null_ff       <= null_in;
         bundle_ff     <= bundle_in;
         tag_total_ff  <= tag_total_in;
         arg_count_ff  <= arg_count_in;
         cursor_ff     <= cursor_in;
         gather_ff     <= gather_in;
         bytes_left_ff <= bytes_left_in;
         elem_left_ff  <= elem_left_in;
         msg_count_ff  <= msg_count_in;
         err_ff        <= err_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/osc_packet_byte_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_packet_byte_parser
// OSC 1.0 packet parser that labels every byte of a message or bundle.
// ----------------------------------------------------------------------------
// Takes one packet byte per transaction and returns one labeled result per
// byte, in order. Sustained rate is one byte per clock while the result side
// is ready; a byte goes through an input register, one pass of parse logic
// and a result register, which presents its result. The argument list of the
// current message lives in a MAX_TAGS-entry memory read one entry ahead;
// no clearing pass is needed after reset. Either register may hold a
// transaction while the other side stalls.
// ----------------------------------------------------------------------------
module osc_packet_byte_parser
   import opbp_pkg::*;
#(
   parameter int MAX_TAGS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   opbp_req_if.sink    req_bus,
   opbp_rsp_if.source  rsp_bus
);

   localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int CW = $clog2(MAX_TAGS + 1);

   logic          in_valid_ff;
   req_type       in_data_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          advance;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   tag_entry_type wr_data;
   tag_entry_type rd_data;
   rsp_type       rsp_next;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_data_ff.data_byte  <= req_bus.data_byte;
         in_data_ff.packet_end <= req_bus.packet_end;
      end
   end

   opbp_parser #(
      .MAX_TAGS (MAX_TAGS),
      .AW       (AW),
      .CW       (CW)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rsp     (rsp_next)
   );

   opbp_tag_mem #(
      .DEPTH (MAX_TAGS),
      .AW    (AW)
   ) u_tag_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.byte_class     = rsp_data_ff.byte_class;
   assign rsp_bus.message_number = rsp_data_ff.message_number;
   assign rsp_bus.arg_number     = rsp_data_ff.arg_number;
   assign rsp_bus.arg_kind       = rsp_data_ff.arg_kind;
   assign rsp_bus.word_lane      = rsp_data_ff.word_lane;
   assign rsp_bus.message_done   = rsp_data_ff.message_done;
   assign rsp_bus.packet_done    = rsp_data_ff.packet_done;
   assign rsp_bus.error_code     = rsp_data_ff.error_code;

endmodule
`default_nettype wire

// ----- bench/tb_osc_packet_byte_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_osc_packet_byte_parser
// Self-checking bench for the OSC packet byte parser. Streams directed and
// random packets (messages, bundles, truncated, malformed and noise), labels
// each accepted byte with a local parser model and checks every result
// transaction field by field, in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_osc_packet_byte_parser;
   import opbp_pkg::*;

   localparam int TAG_DEPTH    = 16;
   localparam int RANDOM_BYTES = 100;
   localparam int SAT_ELEMENTS = 258;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;
   localparam int IDLE_PCT     = 20;
   localparam int STEADY_FROM  = 600;
   localparam int STEADY_TO    = 1000;

   localparam logic [63:0] BUNDLE_MAGIC = {CHAR_HASH, "bundle", CHAR_NUL};

   typedef enum logic [3:0] {
      P_START, P_HEADER, P_TIMETAG, P_ELEM, P_ADDR, P_TAG_FIRST, P_TAGS, P_WORD,
      P_STR, P_BSIZE, P_BDATA, P_BPAD, P_SKIP, P_FILL, P_DISCARD
   } parse_phase_type;

   logic clock;
   logic reset;

   opbp_req_if req_bus ();
   opbp_rsp_if rsp_bus ();

   osc_packet_byte_parser #(.MAX_TAGS(TAG_DEPTH)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Parser model state
   parse_phase_type ps_phase;
   logic [3:0]   ps_count;
   logic [1:0]   ps_lane;
   logic         ps_null;
   logic         ps_bundle;
   logic [2:0]   ps_tags [TAG_DEPTH];
   logic [4:0]   ps_tag_total;
   logic [4:0]   ps_cursor;
   logic [31:0]  ps_gather;
   logic [31:0]  ps_blob_left;
   logic [31:0]  ps_elem_left;
   logic [7:0]   ps_msg_count;
   logic [2:0]   ps_error;

   req_type      pending_bytes [$];
   rsp_type      labels_due [$];
   logic [7:0]   pkt_bytes [$];
   int           bytes_taken = 0;
   int           fault_count = 0;
   logic         steady;

   assign steady = (bytes_taken >= STEADY_FROM) && (bytes_taken < STEADY_TO);

   function automatic void parser_clear();
      ps_phase     = P_START;
      ps_count     = '0;
      ps_lane      = '0;
      ps_null      = 1'b0;
      ps_bundle    = 1'b0;
      ps_tag_total = '0;
      ps_cursor    = '0;
      ps_gather    = '0;
      ps_blob_left = '0;
      ps_elem_left = '0;
      ps_msg_count = '0;
      ps_error     = ERR_NONE;
      for (int i = 0; i < TAG_DEPTH; i++)
         ps_tags[i] = TAG_INT;
   endfunction

   function automatic void latch_error(input logic [2:0] code);
      if (ps_error == ERR_NONE)
         ps_error = code;
   endfunction

   function automatic void open_message();
      ps_phase     = P_ADDR;
      ps_null      = 1'b0;
      ps_tag_total = '0;
      ps_cursor    = '0;
   endfunction

   // Move to the next argument that carries bytes; 1 when the list is used up.
   function automatic bit advance_arg(input int start);
      int idx;
      idx = start;
      while (idx < ps_tag_total && idx < TAG_DEPTH && ps_tags[idx] == TAG_OTHER)
         idx++;
      ps_cursor = idx[4:0];
      if (idx >= ps_tag_total || idx >= TAG_DEPTH)
         return 1'b1;
      case (ps_tags[idx])
         TAG_STRING: begin
            ps_phase = P_STR;
            ps_null  = 1'b0;
         end
         TAG_BLOB: begin
            ps_phase  = P_BSIZE;
            ps_count  = '0;
            ps_gather = '0;
         end
         default: begin
            ps_phase = P_WORD;
            ps_count = '0;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic rsp_type label_byte(input logic [7:0] b, input logic endp);
      rsp_type      r;
      logic [1:0]   lane;
      logic [3:0]   cls;
      logic [3:0]   argn;
      logic [1:0]   kind;
      logic         done;
      logic [7:0]   msgnum;
      logic [2:0]   code;
      parse_phase_type entry_phase;
      bit           finished;
      bit           clean;
      lane     = ps_lane;
      cls      = CLS_STRING_PAD;
      argn     = '0;
      kind     = KIND_INT;
      done     = 1'b0;
      msgnum   = ps_msg_count;
      finished = 1'b0;

      if (ps_phase == P_START) begin
         if (b == CHAR_HASH) begin
            ps_phase = P_HEADER;
            ps_count = '0;
         end else begin
            ps_bundle = 1'b0;
            open_message();
         end
      end
      entry_phase = ps_phase;

      if (ps_phase >= P_WORD && ps_phase <= P_BPAD && ps_cursor < TAG_DEPTH) begin
         argn = ps_cursor[3:0];
         kind = ps_tags[ps_cursor[3:0]][1:0];
      end

      case (ps_phase)
         P_HEADER: begin
            cls = CLS_BUNDLE_HDR;
            if (b != BUNDLE_MAGIC[8 * (7 - int'(ps_count[2:0])) +: 8]) begin
               latch_error(ERR_BAD_HEADER);
               ps_phase = P_DISCARD;
            end else begin
               ps_count = ps_count + 4'd1;
               if (ps_count >= 4'd8) begin
                  ps_bundle = 1'b1;
                  ps_phase  = P_TIMETAG;
                  ps_count  = '0;
               end
            end
         end
         P_TIMETAG: begin
            cls      = CLS_TIMETAG;
            ps_count = ps_count + 4'd1;
            if (ps_count >= 4'd8) begin
               ps_phase  = P_ELEM;
               ps_count  = '0;
               ps_gather = '0;
            end
         end
         P_ELEM: begin
            cls       = CLS_ELEM_SIZE;
            ps_gather = {ps_gather[23:0], b};
            ps_count  = ps_count + 4'd1;
            if (ps_count >= 4'd4) begin
               ps_count     = '0;
               ps_elem_left = ps_gather;
               ps_gather    = '0;
               if (ps_elem_left != 0)
                  open_message();
            end
         end
         P_ADDR: begin
            if (b == CHAR_NUL)
               ps_null = 1'b1;
            cls = ps_null ? CLS_ADDR_PAD : CLS_ADDR;
            if (ps_null && lane == 2'd3) begin
               ps_null  = 1'b0;
               ps_phase = P_TAG_FIRST;
            end
         end
         P_TAG_FIRST: begin
            cls = CLS_TAG;
            if (b == CHAR_COMMA) begin
               ps_phase = P_TAGS;
               ps_null  = 1'b0;
            end else begin
               latch_error(ERR_NO_COMMA);
               ps_phase = P_SKIP;
            end
         end
         P_TAGS: begin
            if (!ps_null && b != CHAR_NUL) begin
               cls = CLS_TAG;
               if (ps_tag_total >= TAG_DEPTH) begin
                  latch_error(ERR_TOO_MANY);
                  ps_phase = P_SKIP;
               end else begin
                  case (b)
                     CHAR_I:  code = TAG_INT;
                     CHAR_F:  code = TAG_FLOAT;
                     CHAR_S:  code = TAG_STRING;
                     CHAR_B:  code = TAG_BLOB;
                     default: code = TAG_OTHER;
                  endcase
                  ps_tags[ps_tag_total[3:0]] = code;
                  ps_tag_total = ps_tag_total + 5'd1;
               end
            end else begin
               ps_null = 1'b1;
               cls     = CLS_TAG_PAD;
               if (lane == 2'd3) begin
                  ps_null  = 1'b0;
                  finished = advance_arg(0);
               end
            end
         end
         P_WORD: begin
            cls      = (kind == KIND_FLOAT) ? CLS_FLOAT : CLS_INT;
            ps_count = ps_count + 4'd1;
            if (ps_count >= 4'd4)
               finished = advance_arg(int'(ps_cursor) + 1);
         end
         P_STR: begin
            if (b == CHAR_NUL)
               ps_null = 1'b1;
            cls = ps_null ? CLS_STRING_PAD : CLS_STRING;
            if (ps_null && lane == 2'd3) begin
               ps_null  = 1'b0;
               finished = advance_arg(int'(ps_cursor) + 1);
            end
         end
         P_BSIZE: begin
            cls       = CLS_BLOB_SIZE;
            ps_gather = {ps_gather[23:0], b};
            ps_count  = ps_count + 4'd1;
            if (ps_count >= 4'd4) begin
               ps_blob_left = ps_gather;
               ps_gather    = '0;
               if (ps_blob_left != 0)
                  ps_phase = P_BDATA;
               else if (lane == 2'd3)
                  finished = advance_arg(int'(ps_cursor) + 1);
               else
                  ps_phase = P_BPAD;
            end
         end
         P_BDATA: begin
            cls = CLS_BLOB_DATA;
            if (ps_blob_left != 0)
               ps_blob_left = ps_blob_left - 32'd1;
            if (ps_blob_left == 0) begin
               if (lane == 2'd3)
                  finished = advance_arg(int'(ps_cursor) + 1);
               else
                  ps_phase = P_BPAD;
            end
         end
         P_BPAD: begin
            cls = CLS_BLOB_PAD;
            if (lane == 2'd3)
               finished = advance_arg(int'(ps_cursor) + 1);
         end
         P_SKIP, P_FILL: begin
            cls = CLS_STRING_PAD;
         end
         default: begin
            cls      = CLS_BUNDLE_HDR;
            ps_phase = P_DISCARD;
         end
      endcase

      if (finished) begin
         ps_phase = P_FILL;
         if (!ps_bundle) begin
            done = 1'b1;
            if (ps_msg_count < 8'd255)
               ps_msg_count = ps_msg_count + 8'd1;
         end
      end

      if (ps_bundle && entry_phase >= P_ADDR && entry_phase <= P_FILL) begin
         if (ps_elem_left != 0)
            ps_elem_left = ps_elem_left - 32'd1;
         if (ps_elem_left == 0) begin
            if (ps_phase != P_TAG_FIRST && ps_phase != P_FILL)
               latch_error(ERR_EARLY_END);
            done = 1'b1;
            if (ps_msg_count < 8'd255)
               ps_msg_count = ps_msg_count + 8'd1;
            ps_phase  = P_ELEM;
            ps_count  = '0;
            ps_gather = '0;
         end
      end

      if (endp) begin
         if (ps_phase == P_DISCARD)
            clean = 1'b1;
         else if (ps_bundle)
            clean = (ps_phase == P_ELEM && ps_count == 0);
         else
            clean = (ps_phase == P_TAG_FIRST || ps_phase == P_FILL);
         if (!clean)
            latch_error(ERR_EARLY_END);
         if ((ps_phase >= P_ADDR && ps_phase <= P_SKIP) || (ps_bundle && ps_phase == P_FILL))
            done = 1'b1;
      end

      r.byte_class     = cls;
      r.message_number = msgnum;
      r.arg_number     = argn;
      r.arg_kind       = kind;
      r.word_lane      = lane;
      r.message_done   = done;
      r.packet_done    = endp;
      r.error_code     = ps_error;

      ps_lane = ps_lane + 2'd1;
      if (endp)
         parser_clear();
      return r;
   endfunction

   // Packet construction
   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] text_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic void put(input logic [7:0] b);
      pkt_bytes.insert(pkt_bytes.size(), b);
   endfunction

   function automatic void pad_after_null();
      put(CHAR_NUL);
      while (pkt_bytes.size() % 4 != 0)
         put(any_byte());
   endfunction

   function automatic int pick_tag_count();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return -1;
      if (r == 1)
         return $urandom_range(TAG_DEPTH + 1, TAG_DEPTH + 3);
      if (r == 2)
         return TAG_DEPTH;
      return $urandom_range(0, 5);
   endfunction

   function automatic void build_message(input int tag_count, input bit with_comma);
      logic [7:0] tags [$];
      logic [7:0] ch;
      int         len;
      put("/");
      repeat ($urandom_range(0, 6))
         put(text_byte());
      pad_after_null();
      if (tag_count < 0)
         return;
      if (with_comma) begin
         put(CHAR_COMMA);
      end else begin
         do ch = any_byte(); while (ch == CHAR_COMMA);
         put(ch);
      end
      for (int i = 0; i < tag_count; i++) begin
         case ($urandom_range(0, 4))
            0:       ch = CHAR_I;
            1:       ch = CHAR_F;
            2:       ch = CHAR_S;
            3:       ch = CHAR_B;
            default: begin
               do ch = text_byte();
               while (ch == CHAR_I || ch == CHAR_F || ch == CHAR_S || ch == CHAR_B);
            end
         endcase
         tags.insert(tags.size(), ch);
         put(ch);
      end
      pad_after_null();
      foreach (tags[i]) begin
         case (tags[i])
            CHAR_I, CHAR_F: begin
               repeat (4) put(any_byte());
            end
            CHAR_S: begin
               repeat ($urandom_range(0, 7)) put(text_byte());
               pad_after_null();
            end
            CHAR_B: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
               put(CHAR_NUL);
               put(CHAR_NUL);
               put(CHAR_NUL);
               put(len[7:0]);
               repeat (len) put(any_byte());
               while (pkt_bytes.size() % 4 != 0)
                  put(any_byte());
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void build_bundle(input int elements);
      int          start;
      int          want;
      logic [31:0] size;
      for (int i = 0; i < 8; i++)
         put(BUNDLE_MAGIC[8 * (7 - i) +: 8]);
      repeat (8) put(any_byte());
      for (int e = 0; e < elements; e++) begin
         start = pkt_bytes.size() + 4;
         repeat (4) put(CHAR_NUL);
         if ($urandom_range(0, 9) == 0)
            continue;
         build_message(pick_tag_count(), 1'b1);
         want = pkt_bytes.size() - start;
         if ($urandom_range(0, 5) == 0)
            want = want + $urandom_range(0, 10) - 5;
         if (want < 1)
            want = 1;
         while (pkt_bytes.size() - start > want)
            void'(pkt_bytes.pop_back());
         while (pkt_bytes.size() - start < want)
            put(any_byte());
         size = want;
         pkt_bytes[start - 4] = size[31:24];
         pkt_bytes[start - 3] = size[23:16];
         pkt_bytes[start - 2] = size[15:8];
         pkt_bytes[start - 1] = size[7:0];
      end
   endfunction

   // Queue the built packet, cut to keep bytes when keep is in range.
   function automatic void send_packet(input int keep);
      req_type item;
      if (keep < 1 || keep > pkt_bytes.size())
         keep = pkt_bytes.size();
      for (int i = 0; i < keep; i++) begin
         item.data_byte  = pkt_bytes[i];
         item.packet_end = (i == keep - 1);
         pending_bytes.insert(pending_bytes.size(), item);
      end
      pkt_bytes.delete();
   endfunction

   // Driver
   always @(posedge clock) begin
      req_type item;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.data_byte  <= '0;
         req_bus.packet_end <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            labels_due.insert(labels_due.size(),
                              label_byte(req_bus.data_byte, req_bus.packet_end));
            bytes_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               item = pending_bytes.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.data_byte  <= item.data_byte;
               req_bus.packet_end <= item.packet_end;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.byte_class     = rsp_bus.byte_class;
            got.message_number = rsp_bus.message_number;
            got.arg_number     = rsp_bus.arg_number;
            got.arg_kind       = rsp_bus.arg_kind;
            got.word_lane      = rsp_bus.word_lane;
            got.message_done   = rsp_bus.message_done;
            got.packet_done    = rsp_bus.packet_done;
            got.error_code     = rsp_bus.error_code;
            if (labels_due.size() == 0) begin
               if (fault_count < REPORT_LIMIT)
                  $display("%0t unexpected transaction cls=%0d msg=%0d arg=%0d kind=%0d",
                           $realtime, got.byte_class, got.message_number, got.arg_number,
                           got.arg_kind);
               fault_count++;
            end else begin
               want = labels_due.pop_front();
               if (got.byte_class !== want.byte_class ||
                   got.message_number !== want.message_number ||
                   got.arg_number !== want.arg_number ||
                   got.arg_kind !== want.arg_kind ||
                   got.word_lane !== want.word_lane ||
                   got.message_done !== want.message_done ||
                   got.packet_done !== want.packet_done ||
                   got.error_code !== want.error_code) begin
                  if (fault_count < REPORT_LIMIT) begin
                     $display("%0t mismatch expected cls=%0d msg=%0d arg=%0d kind=%0d lane=%0d %s",
                              $realtime, want.byte_class, want.message_number,
                              want.arg_number, want.arg_kind, want.word_lane,
                              $sformatf("mdone=%0b pdone=%0b err=%0d", want.message_done,
                                        want.packet_done, want.error_code));
                     $display("%0t mismatch actual   cls=%0d msg=%0d arg=%0d kind=%0d lane=%0d %s",
                              $realtime, got.byte_class, got.message_number,
                              got.arg_number, got.arg_kind, got.word_lane,
                              $sformatf("mdone=%0b pdone=%0b err=%0d", got.message_done,
                                        got.packet_done, got.error_code));
                  end
                  fault_count++;
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      int target;
      int pick;
      int keep;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.packet_end = 1'b0;
      rsp_bus.ready      = 1'b0;
      parser_clear();

      // single message with int and unknown tag, extremes of the byte value
      put("/");
      repeat (3) put(CHAR_NUL);
      put(CHAR_COMMA);
      put(CHAR_I);
      put("q");
      put(CHAR_NUL);
      repeat (4) put(8'hff);
      send_packet(0);
      // bad bundle header
      put(CHAR_HASH);
      put("b");
      put("x");
      send_packet(0);
      // missing comma, then end inside the skipped message
      put("a");
      repeat (3) put(CHAR_NUL);
      put("x");
      send_packet(0);
      // end inside the address
      put(8'hff);
      send_packet(0);

      // message counter saturation: many one-byte elements
      build_bundle(0);
      repeat (SAT_ELEMENTS) begin
         put(CHAR_NUL);
         put(CHAR_NUL);
         put(CHAR_NUL);
         put(8'd1);
         put(any_byte());
      end
      send_packet(0);

      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         pick = $urandom_range(0, 19);
         keep = 0;
         if (pick < 7) begin
            build_bundle($urandom_range(1, 3));
         end else if (pick < 14) begin
            build_message(pick_tag_count(), 1'b1);
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 5)) put(any_byte());
         end else if (pick == 14) begin
            build_message($urandom_range(0, 4), 1'b0);
         end else if (pick == 15) begin
            build_message(pick_tag_count(), 1'b1);
            keep = $urandom_range(1, pkt_bytes.size());
         end else if (pick == 16) begin
            build_bundle($urandom_range(1, 3));
            keep = $urandom_range(1, pkt_bytes.size());
         end else if (pick == 17) begin
            build_bundle(1);
            for (int i = 16; i < 20; i++)
               pkt_bytes[i] = any_byte();
         end else if (pick == 18) begin
            put(CHAR_HASH);
            keep = $urandom_range(1, 7);
            for (int i = 1; i < keep; i++)
               put(BUNDLE_MAGIC[8 * (7 - i) +: 8]);
            put(any_byte());
            repeat ($urandom_range(0, 4)) put(any_byte());
            keep = 0;
         end else begin
            repeat ($urandom_range(1, 8)) put(any_byte());
         end
         send_packet(keep);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_bus.valid)
         @(negedge clock);
      while (labels_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fault_count == 0 && labels_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
